### design/arxh_pkg.sv
// Shared types, round constants and round-step functions for the ARX hash lanes.
`default_nettype none
package arxh_pkg;

  localparam int WORD_W          = 64;
  localparam int STATE_WORDS     = 8;
  localparam int IN_LANES        = 2;
  localparam int LANES_DEF       = 2;
  localparam int ABSORB_STEPS    = 4;
  localparam int PERMS           = ABSORB_STEPS + 12;
  localparam int ROUNDS_PER_PERM = 4;
  localparam int TOTAL_ROUNDS    = PERMS * ROUNDS_PER_PERM;
  // The input word is needed up to the first round of the last absorb step
  localparam int X_ROUNDS        = (ABSORB_STEPS - 1) * ROUNDS_PER_PERM;
  // Two register stages per round
  localparam int PIPE_DEPTH      = 2 * TOTAL_ROUNDS;

  localparam int unsigned ROT_ABS0 = 37;
  localparam int unsigned ROT_ABS1 = 11;
  localparam int unsigned ROT_ABS2 = 53;
  localparam int unsigned ROT_ABS3 = 29;
  localparam int unsigned ROT_7    = 7;
  localparam int unsigned ROT_15   = 15;
  localparam int unsigned ROT_17   = 17;
  localparam int unsigned ROT_19   = 19;
  localparam int unsigned ROT_33   = 33;
  localparam int unsigned ROT_55   = 55;
  localparam int unsigned ROT_61   = 61;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [STATE_WORDS-1:0] state_t;
  typedef logic [1:0] rnd_t;

  // Values after the first half of a round
  typedef struct packed {
    word_t n0;
    word_t n1;
    word_t n2;
    word_t n4;
    word_t n5;
    word_t s45;
    word_t m0;
    word_t m1;
  } mid_t;

  // Values after the second half of a round; word 6 is still pending
  typedef struct packed {
    word_t m0;
    word_t m1;
    word_t m2;
    word_t m3;
    word_t m4;
    word_t m5;
    word_t m7;
    word_t n6;
  } part_t;

  localparam word_t RC [4][4] = '{
    '{64'hfb37a30bfc6db00c, 64'h20aaa580ab0a543f, 64'hb70a723a66323117, 64'hed04db3275575ad5},
    '{64'h3991c4cbc30d5123, 64'ha9a299f2f2dff247, 64'h93a843501e1a53ca, 64'h06f9e304c9f9a41b},
    '{64'h20b718f96dd87e14, 64'h14e55ef766fc546d, 64'h627742d047ae3954, 64'h3b4b414740da6435},
    '{64'hd94681a60fdb761f, 64'h9174fc91c8cb7be3, 64'ha6cbe0eb14ee8ee5, 64'hfe62ab0a0cdfb64f}
  };

  // Rotate right by a constant amount between 1 and 63
  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic state_t absorb(state_t w, word_t x);
    state_t s;
    s    = w;
    s[0] = w[0] ^ rotr(x, ROT_ABS0);
    s[1] = w[1] ^ rotr(x, ROT_ABS1);
    s[2] = w[2] ^ rotr(x, ROT_ABS2);
    s[3] = w[3] ^ rotr(x, ROT_ABS3);
    return s;
  endfunction

  // First half of a round: at most two chained adds
  function automatic mid_t round_a(state_t w, rnd_t r);
    mid_t  m;
    word_t k03;
    k03   = RC[r][0] + RC[r][3];
    m.n0  = (w[1] + w[3]) ^ k03;
    m.n1  = rotr(w[2], ROT_15) + w[3];
    m.n4  = (w[5] + w[7]) ^ k03;
    m.n5  = rotr(w[6], ROT_33);
    m.n2  = (rotr(m.n0 ^ m.n1, ROT_61) + RC[r][1]) ^ RC[r][2];
    m.m0  = m.n0 ^ (rotr(m.n4, ROT_19) + RC[r][0]);
    m.m1  = rotr(m.n1 + m.n5, ROT_55);
    m.s45 = m.n4 + m.n5;
    return m;
  endfunction

  // Second half of a round: at most two chained adds
  function automatic part_t round_b(mid_t x, rnd_t r);
    part_t p;
    word_t n3;
    word_t n7;
    p.n6 = (rotr(x.s45, ROT_17) + RC[r][1]) ^ RC[r][2];
    n3   = x.n1 ^ (x.n2 + rotr(x.n0, ROT_19));
    n7   = x.n5 ^ (p.n6 + rotr(x.n0, ROT_19));
    p.m0 = x.m0;
    p.m1 = x.m1;
    p.m2 = (x.n2 + p.n6) ^ rotr(RC[r][2] ^ p.n6, ROT_7);
    p.m3 = rotr(n3 ^ n7, ROT_15) ^ RC[r][3];
    p.m4 = x.n4 ^ (rotr(x.m0, ROT_19) + RC[r][0]);
    p.m5 = rotr(x.n5 + x.m1, ROT_55);
    p.m7 = rotr(n7 ^ p.m3, ROT_15) ^ RC[r][3];
    return p;
  endfunction

  // Close a round: word 6 takes one more add
  function automatic state_t finish(part_t p, rnd_t r);
    state_t s;
    s[0] = p.m0;
    s[1] = p.m1;
    s[2] = p.m2;
    s[3] = p.m3;
    s[4] = p.m4;
    s[5] = p.m5;
    s[6] = (p.n6 + p.m2) ^ rotr(RC[r][2] ^ p.n6, ROT_7);
    s[7] = p.m7;
    return s;
  endfunction

endpackage
`default_nettype wire

### design/arxh_if.sv
// Valid/ready channel interfaces for input words and hash results.
`default_nettype none
interface arxh_in_if;
  logic          valid;
  logic          ready;
  arxh_pkg::word_t word_low;
  arxh_pkg::word_t word_high;

  modport source (output valid, output word_low, output word_high, input ready);
  modport sink   (input valid, input word_low, input word_high, output ready);
endinterface

interface arxh_out_if;
  logic          valid;
  logic          ready;
  arxh_pkg::word_t hash_low;
  arxh_pkg::word_t hash_high;

  modport source (output valid, output hash_low, output hash_high, input ready);
  modport sink   (input valid, input hash_low, input hash_high, output ready);
endinterface
`default_nettype wire

### design/arxh_lane.sv
// One hash lane: 64 rounds, two register stages per round, advancing on enable.
`default_nettype none
module arxh_lane (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire arxh_pkg::word_t x_in,
  output arxh_pkg::word_t      hash
);

  localparam int LAST = arxh_pkg::TOTAL_ROUNDS - 1;

  arxh_pkg::mid_t  mid_r  [arxh_pkg::TOTAL_ROUNDS];
  arxh_pkg::part_t part_r [arxh_pkg::TOTAL_ROUNDS];
  arxh_pkg::word_t xa_r   [arxh_pkg::X_ROUNDS];
  arxh_pkg::word_t xb_r   [arxh_pkg::X_ROUNDS];
  arxh_pkg::state_t last_s;

  // Carry the input word alongside until the last absorb step
  for (genvar g = 0; g < arxh_pkg::X_ROUNDS; g++) begin : g_xd
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          xa_r[g] <= x_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          xa_r[g] <= xb_r[g-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xb_r[g] <= xa_r[g];
      end
    end
  end

  for (genvar g = 0; g < arxh_pkg::TOTAL_ROUNDS; g++) begin : g_rnd
    localparam arxh_pkg::rnd_t RND = 2'(g % arxh_pkg::ROUNDS_PER_PERM);
    arxh_pkg::state_t a_in;

    if (g == 0) begin : g_start
      assign a_in = arxh_pkg::absorb('0, x_in);
    end else begin : g_chain
      localparam arxh_pkg::rnd_t PRND = 2'((g - 1) % arxh_pkg::ROUNDS_PER_PERM);
      if ((g % arxh_pkg::ROUNDS_PER_PERM) == 0 &&
          (g / arxh_pkg::ROUNDS_PER_PERM) < arxh_pkg::ABSORB_STEPS) begin : g_abs
        assign a_in = arxh_pkg::absorb(arxh_pkg::finish(part_r[g-1], PRND), xb_r[g-1]);
      end else begin : g_plain
        assign a_in = arxh_pkg::finish(part_r[g-1], PRND);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mid_r[g]  <= arxh_pkg::round_a(a_in, RND);
        part_r[g] <= arxh_pkg::round_b(mid_r[g], RND);
      end
    end
  end

  assign last_s = arxh_pkg::finish(part_r[LAST], 2'(LAST % arxh_pkg::ROUNDS_PER_PERM));
  assign hash   = last_s[0] ^ last_s[2] ^ last_s[4] ^ last_s[6];

endmodule
`default_nettype wire

### design/arxh_merge.sv
// Valid line for the lane pipelines and output register with skid stage merging lane hashes.
`default_nettype none
module arxh_merge (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_fire,
  input  wire arxh_pkg::word_t [arxh_pkg::IN_LANES-1:0] lane_hash,
  output logic                                          en,
  arxh_out_if.source                                    out_ch
);

  localparam int D = arxh_pkg::PIPE_DEPTH;

  logic [D-1:0] vld_r;
  logic [D-1:0] vld_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  arxh_pkg::word_t [arxh_pkg::IN_LANES-1:0] out_hash_r, out_hash_nxt;
  arxh_pkg::word_t [arxh_pkg::IN_LANES-1:0] skid_hash_r, skid_hash_nxt;
  logic         pipe_v;
  logic         out_free;

  // Stall the lanes only while the skid stage holds a word
  assign en       = !skid_valid_r;
  assign pipe_v   = vld_r[D-1] && en;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_hash_nxt   = out_hash_r;
    skid_hash_nxt  = skid_hash_r;
    if (en) begin
      vld_nxt = {vld_r[D-2:0], in_fire};
    end
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_hash_nxt   = skid_hash_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = pipe_v;
        if (pipe_v) begin
          out_hash_nxt = lane_hash;
        end
      end
    end else if (pipe_v) begin
      // Park the word leaving the lanes while the output waits
      skid_valid_nxt = 1'b1;
      skid_hash_nxt  = lane_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_hash_r  <= out_hash_nxt;
    skid_hash_r <= skid_hash_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hash_low  = out_hash_r[0];
  assign out_ch.hash_high = out_hash_r[1];

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a word while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_valid_r && out_valid_r && !out_ch.ready && vld_r[D-1] |=> skid_valid_r)
    else $error("word leaving lanes during output stall was not parked");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> $stable(vld_r))
    else $error("valid line moved while lanes were stalled");

  a_no_fire_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> !vld_r[0] || $past(vld_r[0]))
    else $error("word entered lanes while stalled");
`endif

endmodule
`default_nettype wire

### design/dual_lane_arx_hash64.sv
// Latency: a word accepted by the lanes passes two register stages per round over
// 64 rounds, with the last round closed into the output register.
// Throughput: one word per cycle while the lanes are not stalled, through the fully pipelined rounds of each lane.
// An output stall is absorbed by one skid stage; the lanes stop only while it is full.
// Reset (synchronous, active low) clears the valid line, output valid and skid valid;
// data registers are not reset.
`default_nettype none
module dual_lane_arx_hash64 #(
  parameter int LANES = arxh_pkg::LANES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  arxh_in_if.sink   in_ch,
  arxh_out_if.source out_ch
);

  localparam int NL = (LANES < arxh_pkg::IN_LANES) ? LANES : arxh_pkg::IN_LANES;

  logic en;
  logic in_fire;
  arxh_pkg::word_t [arxh_pkg::IN_LANES-1:0] lane_word;
  arxh_pkg::word_t [arxh_pkg::IN_LANES-1:0] lane_hash;

  assign in_ch.ready  = en;
  assign in_fire      = in_ch.valid && en;
  assign lane_word[0] = in_ch.word_low;
  assign lane_word[1] = in_ch.word_high;

  for (genvar l = 0; l < arxh_pkg::IN_LANES; l++) begin : g_lane
    if (l < NL) begin : g_on
      arxh_lane u_lane (
        .clk  (clk),
        .en   (en),
        .x_in (lane_word[l]),
        .hash (lane_hash[l])
      );
    end else begin : g_off
      // Lanes left out report zero
      assign lane_hash[l] = '0;
    end
  end

  arxh_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .lane_hash (lane_hash),
    .en        (en),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### tb/dual_lane_arx_hash64_test.sv
// Self-checking test of the two-lane 64-bit ARX hash pipeline with random flow control.
module dual_lane_arx_hash64_test;
  typedef arxh_pkg::word_t word_t;

  localparam int LANE_COUNT = 2;
  localparam int DRAIN_CYCLES = 140;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam word_t ROUND_KEY [4][4] = '{
    '{64'hfb37a30bfc6db00c, 64'h20aaa580ab0a543f, 64'hb70a723a66323117, 64'hed04db3275575ad5},
    '{64'h3991c4cbc30d5123, 64'ha9a299f2f2dff247, 64'h93a843501e1a53ca, 64'h06f9e304c9f9a41b},
    '{64'h20b718f96dd87e14, 64'h14e55ef766fc546d, 64'h627742d047ae3954, 64'h3b4b414740da6435},
    '{64'hd94681a60fdb761f, 64'h9174fc91c8cb7be3, 64'ha6cbe0eb14ee8ee5, 64'hfe62ab0a0cdfb64f}
  };

  typedef word_t [7:0] lane_state_t;

  typedef struct packed {
    word_t lo;
    word_t hi;
  } hash_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  arxh_in_if in_ch();
  arxh_out_if out_ch();

  dual_lane_arx_hash64 #(.LANES(LANE_COUNT)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hash_pair_t pending_hashes[$];
  int err_count = 0;
  bit src_idle;
  logic sink_idle;
  logic long_hold_req;
  logic hold_req_q;
  int stall_cnt;
  int quiet_cycles;

  function automatic word_t ror64(word_t v, int unsigned n);
    logic [127:0] d;
    d = {v, v} >> n;
    return d[63:0];
  endfunction

  function automatic lane_state_t permute(lane_state_t s);
    word_t k0, k1, k2, k3;
    for (int r = 0; r < 4; r++) begin
      k0 = ROUND_KEY[r][0];
      k1 = ROUND_KEY[r][1];
      k2 = ROUND_KEY[r][2];
      k3 = ROUND_KEY[r][3];
      // Words update in order; later lines see values written above
      s[0] = (s[1] + s[3]) ^ (k0 + k3);
      s[1] = ror64(s[2], 15) + s[3];
      s[2] = (ror64(s[0] ^ s[1], 61) + k1) ^ k2;
      s[3] = s[1] ^ (s[2] + ror64(s[0], 19));
      s[4] = (s[5] + s[7]) ^ (k0 + k3);
      s[5] = ror64(s[6], 33);
      s[6] = (ror64(s[4] + s[5], 17) + k1) ^ k2;
      s[7] = s[5] ^ (s[6] + ror64(s[0], 19));
      s[0] = s[0] ^ (ror64(s[4], 19) + k0);
      s[1] = ror64(s[1] + s[5], 55);
      s[2] = (s[2] + s[6]) ^ ror64(k2 ^ s[6], 7);
      s[3] = ror64(s[3] ^ s[7], 15) ^ k3;
      s[4] = s[4] ^ (ror64(s[0], 19) + k0);
      s[5] = ror64(s[5] + s[1], 55);
      s[6] = (s[6] + s[2]) ^ ror64(k2 ^ s[6], 7);
      s[7] = ror64(s[7] ^ s[3], 15) ^ k3;
    end
    return s;
  endfunction

  function automatic word_t lane_digest(word_t x);
    lane_state_t s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s[0] = s[0] ^ ror64(x, 37);
      s[1] = s[1] ^ ror64(x, 11);
      s[2] = s[2] ^ ror64(x, 53);
      s[3] = s[3] ^ ror64(x, 29);
      s = permute(s);
    end
    for (int i = 0; i < 12; i++)
      s = permute(s);
    return s[0] ^ s[2] ^ s[4] ^ s[6];
  endfunction

  function automatic hash_pair_t hash_pair(word_t lo, word_t hi);
    hash_pair_t p;
    p.lo = lane_digest(lo);
    p.hi = (LANE_COUNT > 1) ? lane_digest(hi) : '0;
    return p;
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Compare each result word, then record the word accepted at this edge
  always @(posedge clk) begin
    hash_pair_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_hashes.size() == 0) begin
          report($sformatf("unexpected result %h %h", out_ch.hash_low, out_ch.hash_high));
        end else begin
          want = pending_hashes.pop_front();
          if (out_ch.hash_low !== want.lo)
            report($sformatf("hash_low %h, expected %h", out_ch.hash_low, want.lo));
          if (out_ch.hash_high !== want.hi)
            report($sformatf("hash_high %h, expected %h", out_ch.hash_high, want.hi));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_hashes.push_back(hash_pair(in_ch.word_low, in_ch.word_high));
    end
  end

  // Receiver: random short stalls while sink_idle is set, or one long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall_cnt <= 0;
      hold_req_q <= 1'b0;
    end else begin
      hold_req_q <= long_hold_req;
      if (long_hold_req && !hold_req_q) begin
        out_ch.ready <= 1'b0;
        stall_cnt <= LONG_HOLD - 1;
      end else if (stall_cnt != 0) begin
        out_ch.ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_cnt <= $urandom_range(1, 3) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_word(input word_t lo, input word_t hi);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word_low <= lo;
    in_ch.word_high <= hi;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    word_t v;
    case ($urandom_range(0, 5))
      0: v = word_t'(1) << $urandom_range(0, 63);
      1: v = ~(word_t'(1) << $urandom_range(0, 63));
      2: v = word_t'($urandom_range(0, 255));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic test_edge_values();
    word_t vals[16];
    vals = '{64'h0, 64'hffffffffffffffff, 64'h1, 64'h8000000000000000,
             64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h00000000ffffffff,
             64'hffffffff00000000, 64'h0000002000000000, 64'h0000000000000800,
             64'h0020000000000000, 64'h0000000020000000, 64'h7fffffffffffffff,
             64'hfffffffffffffffe, 64'hfb37a30bfc6db00c, 64'h0123456789abcdef};
    src_idle = 1'b0;
    sink_idle <= 1'b0;
    foreach (vals[i])
      send_word(vals[i], vals[15 - i]);
    // Same value in both lanes, and one lane zero with the other full
    send_word(64'hdeadbeefcafef00d, 64'hdeadbeefcafef00d);
    send_word(64'h0, 64'hffffffffffffffff);
    send_word(64'hffffffffffffffff, 64'h0);
  endtask

  task automatic test_random_traffic(input int count);
    src_idle = 1'b1;
    sink_idle <= 1'b1;
    repeat (count) send_word(rand_word(), rand_word());
  endtask

  task automatic test_backpressure_fill(input int count);
    src_idle = 1'b0;
    sink_idle <= 1'b0;
    long_hold_req <= 1'b1;
    repeat (count) send_word(rand_word(), rand_word());
    long_hold_req <= 1'b0;
  endtask

  task automatic test_idle_mix(input int count);
    for (int i = 0; i < count; i++) begin
      // Switch idling on and off in stretches
      if (i % 50 == 0) begin
        src_idle = $urandom_range(0, 1);
        sink_idle <= $urandom_range(0, 1);
      end
      send_word(rand_word(), rand_word());
    end
  endtask

  task automatic test_full_rate(input int count);
    src_idle = 1'b0;
    sink_idle <= 1'b0;
    repeat (count) send_word({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.word_low <= '0;
    in_ch.word_high <= '0;
    sink_idle <= 1'b0;
    long_hold_req <= 1'b0;
    src_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_random_traffic(600);
    test_backpressure_fill(250);
    test_idle_mix(400);
    test_full_rate(180);
    in_ch.valid <= 1'b0;

    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
